// ----- design/signed_alu_sticky_error_flags_defines.svh -----
// assertion macros for the signed alu block
`ifndef SIGNED_ALU_STICKY_ERROR_FLAGS_DEFINES_SVH
`define SIGNED_ALU_STICKY_ERROR_FLAGS_DEFINES_SVH

// implication checked on every edge outside reset
`define SASEF_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("sasef check failed");

// implication checked in the cycle after the condition
`define SASEF_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("sasef check failed");

`endif

// ----- design/sasef_pkg.sv -----
// shared types and opcode constants of the signed alu
package sasef_pkg;

  localparam int DEF_WIDTH = 32;
  localparam int DATA_W    = 32;

  typedef logic [3:0] op_t;

  localparam op_t OP_ADD  = 4'd0;
  localparam op_t OP_SUB  = 4'd1;
  localparam op_t OP_NEG  = 4'd2;
  localparam op_t OP_MUL  = 4'd3;
  localparam op_t OP_MULB = 4'd4;
  localparam op_t OP_DIV  = 4'd5;
  localparam op_t OP_MOD  = 4'd6;
  localparam op_t OP_ABS  = 4'd7;
  localparam op_t OP_SIGN = 4'd8;
  localparam op_t OP_LT   = 4'd9;
  localparam op_t OP_LE   = 4'd10;
  localparam op_t OP_GT   = 4'd11;
  localparam op_t OP_GE   = 4'd12;
  localparam op_t OP_EQ   = 4'd13;
  localparam op_t OP_NE   = 4'd14;

  typedef struct packed {
    op_t  op;
    logic aneg;
    logic bneg;
    logic cmp;
    logic ovf;
    logic dz;
  } ctrl_t;

endpackage

// ----- design/sasef_front.sv -----
// first stage: decode, simple results, multiply, flags and magnitudes
module sasef_front
  import sasef_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  op_t                     op_i,
  input  logic signed [WIDTH-1:0] a_i,
  input  logic signed [WIDTH-1:0] b_i,
  input  logic                    a_ovf_i,
  input  logic                    a_dz_i,
  input  logic                    b_ovf_i,
  input  logic                    b_dz_i,
  input  logic                    safe_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output ctrl_t                   ctrl_o,
  output logic [WIDTH-1:0]        v_o,
  output logic [WIDTH-1:0]        amag_o,
  output logic [WIDTH-1:0]        bmag_o
);

  logic [WIDTH-1:0] sum, diff, neg, prod, v_next;
  logic             take_a, take_b, ovf, cmp, dz;
  logic             aneg, bneg;
  ctrl_t            ctrl_next;

  assign aneg = a_i[WIDTH-1];
  assign bneg = b_i[WIDTH-1];
  assign sum  = a_i + b_i;
  assign diff = a_i - b_i;
  assign neg  = '0 - a_i;
  assign prod = a_i * b_i;
  assign ready_o = !valid_o || ready_i;

  always_comb begin
    v_next = '0;
    cmp    = 1'b0;
    ovf    = 1'b0;
    take_a = 1'b0;
    take_b = 1'b0;
    unique case (op_i)
      OP_ADD: begin
        v_next = sum;
        ovf    = (aneg == bneg) && (sum[WIDTH-1] != aneg);
        take_a = 1'b1;
        take_b = 1'b1;
      end
      OP_SUB: begin
        v_next = diff;
        ovf    = (aneg != bneg) && (diff[WIDTH-1] != aneg);
        take_a = 1'b1;
        take_b = 1'b1;
      end
      OP_NEG: begin
        v_next = neg;
        ovf    = aneg && (a_i[WIDTH-2:0] == '0);
        take_a = 1'b1;
      end
      OP_MUL: begin
        v_next = prod;
        take_a = 1'b1;
        take_b = 1'b1;
      end
      OP_MULB: v_next = b_i[0] ? a_i : '0;
      OP_DIV, OP_MOD: begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
      OP_ABS: begin
        v_next = aneg ? neg : a_i;
        take_a = 1'b1;
      end
      OP_SIGN: v_next = aneg ? '1 : WIDTH'(1);
      OP_LT:   cmp = a_i < b_i;
      OP_LE:   cmp = a_i <= b_i;
      OP_GT:   cmp = b_i < a_i;
      OP_GE:   cmp = b_i <= a_i;
      OP_EQ:   cmp = a_i == b_i;
      OP_NE:   cmp = a_i != b_i;
      default: v_next = '0;
    endcase
    dz = ((op_i == OP_DIV) || (op_i == OP_MOD)) && (b_i == '0);
    dz  = dz  || (take_a && a_dz_i)  || (take_b && b_dz_i);
    ovf = ovf || (take_a && a_ovf_i) || (take_b && b_ovf_i);
    ctrl_next.op   = op_i;
    ctrl_next.aneg = aneg;
    ctrl_next.bneg = bneg;
    ctrl_next.cmp  = cmp;
    ctrl_next.ovf  = ovf && safe_i;
    ctrl_next.dz   = dz && safe_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctrl_o <= ctrl_next;
      v_o    <= v_next;
      amag_o <= aneg ? neg : a_i;
      bmag_o <= bneg ? WIDTH'('0 - b_i) : b_i;
    end
  end

endmodule

// ----- design/sasef_div_step.sv -----
// one restoring division step as a pipeline stage
module sasef_div_step
  import sasef_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_i,
  output logic             ready_o,
  input  ctrl_t            ctrl_i,
  input  logic [WIDTH-1:0] v_i,
  input  logic [WIDTH-1:0] amag_i,
  input  logic [WIDTH-1:0] bmag_i,
  input  logic [WIDTH-1:0] t_i,
  input  logic             r_i,
  input  logic [WIDTH-1:0] quo_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ctrl_t            ctrl_o,
  output logic [WIDTH-1:0] v_o,
  output logic [WIDTH-1:0] amag_o,
  output logic [WIDTH-1:0] bmag_o,
  output logic [WIDTH-1:0] t_o,
  output logic             r_o,
  output logic [WIDTH-1:0] quo_o
);

  localparam int BIT = WIDTH - 1 - IDX;

  logic [WIDTH-1:0] base, t_next, quo_next;
  logic             r_next;

  assign ready_o = !valid_o || ready_i;

  always_comb begin
    base     = r_i ? (t_i - bmag_i) : t_i;
    t_next   = {base[WIDTH-2:0], amag_i[BIT]};
    // signed compare as the scheme defines it, even for magnitudes
    r_next   = $signed(bmag_i) <= $signed(t_next);
    quo_next = quo_i;
    quo_next[BIT] = r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      ctrl_o <= ctrl_i;
      v_o    <= v_i;
      amag_o <= amag_i;
      bmag_o <= bmag_i;
      t_o    <= t_next;
      r_o    <= r_next;
      quo_o  <= quo_next;
    end
  end

endmodule

// ----- design/signed_alu_sticky_error_flags.sv -----
// top level of the pipelined signed alu with sticky error flags
// Signed WIDTH-bit ALU, fully pipelined: one beat can enter every clock while
// in_ready is high, through WIDTH+2 register stages (front stage, WIDTH
// restoring division stages, output register). The division stages set the
// pipeline depth; every operation goes through them so results stay in order.
// Each stage holds its beat until the next stage is free, so a stall on the
// output side fills bubbles before in_ready drops. The user must write
// flag_enable with cfg_we/cfg_wdata only while idle; the block does not enforce
// this. Beats accepted while it is clear get both flag outputs zero.
module signed_alu_sticky_error_flags
  import sasef_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               req_type,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  input  logic                     a_overflow_in,
  input  logic                     a_divzero_in,
  input  logic                     b_overflow_in,
  input  logic                     b_divzero_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] value_out,
  output logic                     compare_out,
  output logic                     overflow_out,
  output logic                     divzero_out
);

  `include "signed_alu_sticky_error_flags_defines.svh"

  logic flag_enable;

  // stage arrays: index 0 is the front stage, index k the kth division step
  logic             s_valid [WIDTH+1];
  logic             s_ready [WIDTH+1];
  ctrl_t            s_ctrl  [WIDTH+1];
  logic [WIDTH-1:0] s_v     [WIDTH+1];
  logic [WIDTH-1:0] s_amag  [WIDTH+1];
  logic [WIDTH-1:0] s_bmag  [WIDTH+1];
  logic [WIDTH-1:0] s_t     [WIDTH+1];
  logic             s_r     [WIDTH+1];
  logic [WIDTH-1:0] s_quo   [WIDTH+1];

  logic signed [WIDTH-1:0] a_w, b_w;
  logic [WIDTH-1:0]        rem, res;
  logic                    last_ready;
  ctrl_t                   lc;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_enable <= 1'b0;
    end else if (cfg_we) begin
      flag_enable <= cfg_wdata;
    end
  end

  // operands sign-extended or cut to the alu width
  assign a_w = WIDTH'(operand_a);
  assign b_w = WIDTH'(operand_b);

  sasef_front #(.WIDTH(WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .op_i    (req_type),
    .a_i     (a_w),
    .b_i     (b_w),
    .a_ovf_i (a_overflow_in),
    .a_dz_i  (a_divzero_in),
    .b_ovf_i (b_overflow_in),
    .b_dz_i  (b_divzero_in),
    .safe_i  (flag_enable),
    .valid_o (s_valid[0]),
    .ready_i (s_ready[0]),
    .ctrl_o  (s_ctrl[0]),
    .v_o     (s_v[0]),
    .amag_o  (s_amag[0]),
    .bmag_o  (s_bmag[0])
  );

  // division starts from an empty partial remainder
  assign s_t[0]   = '0;
  assign s_r[0]   = 1'b0;
  assign s_quo[0] = '0;

  for (genvar k = 0; k < WIDTH; k++) begin : g_div
    sasef_div_step #(.WIDTH(WIDTH), .IDX(k)) u_step (
      .clk     (clk),
      .rst     (rst),
      .valid_i (s_valid[k]),
      .ready_o (s_ready[k]),
      .ctrl_i  (s_ctrl[k]),
      .v_i     (s_v[k]),
      .amag_i  (s_amag[k]),
      .bmag_i  (s_bmag[k]),
      .t_i     (s_t[k]),
      .r_i     (s_r[k]),
      .quo_i   (s_quo[k]),
      .valid_o (s_valid[k+1]),
      .ready_i (s_ready[k+1]),
      .ctrl_o  (s_ctrl[k+1]),
      .v_o     (s_v[k+1]),
      .amag_o  (s_amag[k+1]),
      .bmag_o  (s_bmag[k+1]),
      .t_o     (s_t[k+1]),
      .r_o     (s_r[k+1]),
      .quo_o   (s_quo[k+1])
    );
  end

  // final restore and sign fix for divide and remainder
  assign lc         = s_ctrl[WIDTH];
  assign last_ready = !out_valid || out_ready;
  assign s_ready[WIDTH] = last_ready;
  assign rem = s_r[WIDTH] ? (s_t[WIDTH] - s_bmag[WIDTH]) : s_t[WIDTH];

  always_comb begin
    priority if (lc.op == OP_DIV) begin
      res = (lc.aneg != lc.bneg) ? ('0 - s_quo[WIDTH]) : s_quo[WIDTH];
    end else if (lc.op == OP_MOD) begin
      res = lc.aneg ? ('0 - rem) : rem;
    end else begin
      res = s_v[WIDTH];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_ready) begin
      out_valid <= s_valid[WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && s_valid[WIDTH]) begin
      value_out    <= DATA_W'($signed(res));
      compare_out  <= lc.cmp;
      overflow_out <= lc.ovf;
      divzero_out  <= lc.dz;
    end
  end

  // checks
  `SASEF_ASSERT_IMPL(a_cmp_zero_value, out_valid && compare_out, value_out == '0)
  `SASEF_ASSERT_IMPL(a_flags_need_safe, out_valid && !flag_enable,
                     !overflow_out && !divzero_out)
  `SASEF_ASSERT_NEXT(a_stall_holds_last, s_valid[WIDTH] && out_valid && !out_ready,
                     s_valid[WIDTH])

endmodule

// ----- tb/signed_alu_sticky_error_flags_tb.sv -----
// self-checking testbench for the signed alu with sticky error flags
module signed_alu_sticky_error_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sasef_pkg::*;

  localparam int W = 32;
  localparam int LATENCY = W + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  // one result beat as the block should produce it
  typedef struct packed {
    logic [W-1:0] value;
    logic         cmp;
    logic         ovf;
    logic         dz;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] req_type = '0;
  logic signed [DATA_W-1:0] operand_a = '0;
  logic signed [DATA_W-1:0] operand_b = '0;
  logic a_overflow_in = 1'b0;
  logic a_divzero_in = 1'b0;
  logic b_overflow_in = 1'b0;
  logic b_divzero_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] value_out;
  logic compare_out;
  logic overflow_out;
  logic divzero_out;

  // predictor copy of the one config register
  logic flag_enable_q = 1'b0;
  alu_result_t expected_results[$];
  int failures = 0;
  int cycle_count = 0;
  // when set, the receiver stops accepting for a long stretch
  logic hold_off_req = 1'b0;
  logic hold_off_active = 1'b0;

  signed_alu_sticky_error_flags u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .a_overflow_in(a_overflow_in),
    .a_divzero_in (a_divzero_in),
    .b_overflow_in(b_overflow_in),
    .b_divzero_in (b_divzero_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_out    (value_out),
    .compare_out  (compare_out),
    .overflow_out (overflow_out),
    .divzero_out  (divzero_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_alu_sticky_error_flags_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
    // most negative value maps onto itself
    return x[W-1] ? -x : x;
  endfunction

  function automatic logic signed_le(input logic [W-1:0] x, input logic [W-1:0] y);
    return $signed(x) <= $signed(y);
  endfunction

  // bit-serial restoring division with signed trial compares, as the hardware does
  task automatic restoring_divide(input logic [W-1:0] dividend, input logic [W-1:0] divisor,
                                  output logic [W-1:0] quo, output logic [W-1:0] rem);
    logic [W-1:0] partial;
    logic fits;
    partial = {{(W-1){1'b0}}, dividend[W-1]};
    quo = '0;
    fits = signed_le(divisor, partial);
    quo[W-1] = fits;
    for (int i = 1; i < W; i++) begin
      partial = fits ? ((partial - divisor) << 1) : (partial << 1);
      partial[0] = dividend[W-1-i];
      fits = signed_le(divisor, partial);
      quo[W-1-i] = fits;
    end
    if (fits) partial = partial - divisor;
    rem = partial;
  endtask

  // expected result beat for one request
  task automatic predict_alu(input op_t op, input logic [W-1:0] a, input logic [W-1:0] b,
                             input logic [3:0] flags, output alu_result_t res);
    logic [W-1:0] quo, rem;
    logic ovf, dz, arith, use_a, use_b;
    res = '0;
    ovf = 1'b0;
    dz = 1'b0;
    arith = 1'b1;
    use_a = 1'b0;
    use_b = 1'b0;
    case (op)
      OP_ADD: begin
        res.value = a + b;
        ovf = (a[W-1] == b[W-1]) && (res.value[W-1] != a[W-1]);
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_SUB: begin
        res.value = a - b;
        ovf = (a[W-1] != b[W-1]) && (res.value[W-1] != a[W-1]);
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_NEG: begin
        res.value = -a;
        ovf = (a == MINV);
        use_a = 1'b1;
      end
      OP_MUL: begin
        res.value = a * b;
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_MULB: res.value = b[0] ? a : '0;
      OP_DIV, OP_MOD: begin
        restoring_divide(magnitude(a), magnitude(b), quo, rem);
        if (op == OP_DIV) res.value = (a[W-1] != b[W-1]) ? -quo : quo;
        else res.value = a[W-1] ? -rem : rem;
        dz = (b == '0);
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_ABS: begin
        res.value = magnitude(a);
        use_a = 1'b1;
      end
      OP_SIGN: res.value = a[W-1] ? '1 : W'(1);
      OP_LT: begin res.cmp = $signed(a) < $signed(b); arith = 1'b0; end
      OP_LE: begin res.cmp = $signed(a) <= $signed(b); arith = 1'b0; end
      OP_GT: begin res.cmp = $signed(a) > $signed(b); arith = 1'b0; end
      OP_GE: begin res.cmp = $signed(a) >= $signed(b); arith = 1'b0; end
      OP_EQ: begin res.cmp = (a == b); arith = 1'b0; end
      OP_NE: begin res.cmp = (a != b); arith = 1'b0; end
      default: arith = 1'b0;
    endcase
    if (!arith) res.value = '0;
    // flags order: a_ovf, a_dz, b_ovf, b_dz
    if (use_a) begin ovf |= flags[3]; dz |= flags[2]; end
    if (use_b) begin ovf |= flags[1]; dz |= flags[0]; end
    res.ovf = flag_enable_q & ovf;
    res.dz = flag_enable_q & dz;
  endtask

  // offer one beat after a random gap, hold it until accepted
  task automatic send_request(input op_t op, input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [3:0] flags, input int max_gap = 15);
    alu_result_t res;
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    {a_overflow_in, a_divzero_in, b_overflow_in, b_divzero_in} <= flags;
    do @(posedge clk); while (!in_ready);
    predict_alu(op, a, b, flags, res);
    expected_results.push_back(res);
  endtask

  // drop valid after the last accepted beat
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls per beat, plus a long hold-off on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_off_req && !hold_off_active) begin
        hold_off_active = 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off_active = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    alu_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: value %h", value_out);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (value_out !== exp_res.value) begin
          $error("value_out expected %h actual %h", exp_res.value, value_out);
          failures++;
        end
        if (compare_out !== exp_res.cmp) begin
          $error("compare_out expected %b actual %b", exp_res.cmp, compare_out);
          failures++;
        end
        if (overflow_out !== exp_res.ovf) begin
          $error("overflow_out expected %b actual %b", exp_res.ovf, overflow_out);
          failures++;
        end
        if (divzero_out !== exp_res.dz) begin
          $error("divzero_out expected %b actual %b", exp_res.dz, divzero_out);
          failures++;
        end
      end
    end
  end

  // only touch the config register once the pipe has drained
  task automatic drain_pipe();
    idle_input();
    wait (expected_results.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_flag_enable(input logic val);
    drain_pipe();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    flag_enable_q = val;
  endtask

  function automatic logic [W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0: return MINV;
      1: return MAXV;
      2: return '0;
      3: return $urandom_range(0, 20);
      4: return -$urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // extremes, every opcode, zero divisor, most negative operand, flag paths
  task automatic test_directed();
    op_t op;
    for (int i = 0; i <= 15; i++) begin
      op = op_t'(i);
      send_request(op, MINV, -1, 4'b1010);
    end
    send_request(OP_DIV, 32'sd100, '0, 4'b0000);
    send_request(OP_MOD, -32'sd7, '0, 4'b0101);
    send_request(OP_DIV, MINV, MINV, 4'b0000);
    send_request(OP_MOD, MAXV, MINV, 4'b0000);
    send_request(OP_ADD, MAXV, 32'sd1, 4'b0000);
    send_request(OP_SUB, MINV, 32'sd1, 4'b0000);
    send_request(OP_NEG, MINV, '0, 4'b0000);
    send_request(OP_MUL, MAXV, MAXV, 4'b1111);
    send_request(OP_MULB, MAXV, 32'sd1, 4'b1111);
  endtask

  task automatic test_random(input int count);
    logic [3:0] flags;
    for (int i = 0; i < count; i++) begin
      flags = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b0000;
      send_request(op_t'($urandom_range(0, 15)), random_operand(), random_operand(), flags,
                   (i % 100 < 30) ? 0 : 15);
    end
  endtask

  // back-to-back beats while the receiver stalls, so the pipe fills up
  task automatic test_backpressure();
    idle_input();
    hold_off_req = 1'b1;
    wait (hold_off_active);
    hold_off_req = 1'b0;
    for (int i = 0; i < 80; i++)
      send_request(op_t'($urandom_range(0, 14)), $urandom, $urandom, 4'($urandom), 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    write_flag_enable(1'b1);
    test_directed();
    test_random(400);
    test_backpressure();
    write_flag_enable(1'b0);
    test_random(300);
    write_flag_enable(1'b1);
    test_random(400);
    drain_pipe();
    if (failures == 0) begin
      $display("signed_alu_sticky_error_flags_tb OK");
    end else begin
      $display("signed_alu_sticky_error_flags_tb NOT OK");
    end
    $finish;
  end

endmodule
